// ===== design/nrsq_pkg.sv =====
// ----------------------------------------------------------------------------
// NACK retransmit send queue package
// Shared field widths, function and status codes, payload structs and the
// control and status groups between the top level and the retransmit stack.
// ----------------------------------------------------------------------------
package nrsq_pkg;

  localparam int SEQ_W    = 11;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;

  // Function codes carried on the request channel.
  localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NACK = 2'd2;

  // Status codes carried on the response channel.
  localparam logic [STATUS_W-1:0] ST_SENT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACKED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NACKQ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTOUT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEQ_W-1:0]  seq_num;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_out;
  } rsp_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [SEQ_W-1:0] data;
  } stk_ctl_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [SEQ_W-1:0] top;
  } stk_stat_t;

endpackage

// ===== design/nrsq_ram.sv =====
// ----------------------------------------------------------------------------
// NACK retransmit send queue RAM
// One write port and one registered read port. A read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module nrsq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 11,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== design/nrsq_stack.sv =====
// ----------------------------------------------------------------------------
// NACK retransmit send queue retransmit stack
// LIFO of sequence numbers. The top entry is kept in the RAM's read register
// by reading the entry below the next fill level every cycle.
// ----------------------------------------------------------------------------
module nrsq_stack #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nrsq_pkg::stk_ctl_t   ctl,
  output nrsq_pkg::stk_stat_t  stat
);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [AW-1:0]              rd_addr;
  logic [nrsq_pkg::SEQ_W-1:0] top;

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
  end

  // The entry that will be on top after this cycle.
  assign rd_addr = AW'(count_next - CW'(1));

  nrsq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (nrsq_pkg::SEQ_W)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (count[AW-1:0]),
    .wdata (ctl.data),
    .re    (1'b1),
    .raddr (rd_addr),
    .rdata (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.top   = top;

endmodule

// ===== design/nack_retransmit_send_queue_unit.sv =====
// ----------------------------------------------------------------------------
// NACK retransmit send queue
// Sender-side queue that hands out fresh sequence numbers in order, serves
// NACKed numbers first from a LIFO retransmit stack, and tracks which
// numbers are outstanding.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Beat
//   -------   ---------  ------------------------  ---------------------------
//   cfg       in         cfg_valid / cfg_ready     cfg_data: fresh count limit
//   req       in         req_valid / req_stall     req: func, seq_num
//   rsp       out        rsp_valid / rsp_stall     rsp: status, seq_out
//
// An accepted request beat is registered in the item register, decided there,
// and enters the response register when the item moves on, from where its
// response is offered. One beat is taken every cycle while rsp is not
// stalled. The item stage comes from the outstanding bitmap's registered
// read port, which is addressed with seq_num at the moment the beat is
// accepted. Reset is synchronous; the bitmap needs no clearing pass, since
// any entry at or above next_fresh reads as not outstanding. A stall on
// rsp backs up into the item register and then into req_stall.
//
module nack_retransmit_send_queue_unit #(
  parameter int SEQ_SPACE  = 1024,
  parameter int RETX_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nrsq_pkg::SEQ_W-1:0] cfg_data,

  input  logic                       req_valid,
  output logic                       req_stall,
  input  nrsq_pkg::req_t             req,

  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output nrsq_pkg::rsp_t             rsp
);

  // Bitmap covers numbers 0..SEQ_SPACE. Comparisons run in a width that
  // holds both the 11-bit fields and SEQ_SPACE + 1.
  localparam int MAP_DEPTH = SEQ_SPACE + 1;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int NF_W      = $clog2(SEQ_SPACE + 2);
  localparam int CMP_W     = (NF_W > nrsq_pkg::SEQ_W) ? NF_W : nrsq_pkg::SEQ_W;
  localparam logic [CMP_W-1:0] SPACE_C = CMP_W'(SEQ_SPACE);

  // Configuration register.
  logic [nrsq_pkg::SEQ_W-1:0] num_packets;

  // Item register (first stage) and the bitmap bit read for it.
  logic                       item_valid;
  nrsq_pkg::req_t             item;
  logic [0:0]                 map_bit;

  // Fresh number counter: every number from 1 up to below it has been sent at least once.
  logic [CMP_W-1:0]           next_fresh;

  logic                       accept;
  logic                       adv;

  // Decision logic.
  logic [CMP_W-1:0]           seq_c;
  logic [CMP_W-1:0]           limit;
  logic                       outstanding;
  nrsq_pkg::rsp_t             rsp_next;
  logic                       map_we;
  logic [MAP_AW-1:0]          map_wa;
  logic [0:0]                 map_wd;
  logic [MAP_AW-1:0]          map_ra;
  logic                       fresh_inc;
  nrsq_pkg::stk_ctl_t         stk_ctl;
  nrsq_pkg::stk_stat_t        stk_stat;

  // --------------------------------------------------------------------------
  // Handshakes. The item register moves on when the response register is
  // empty or being emptied; a new beat enters whenever the item register
  // is empty or moving on.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign adv       = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !adv;
  assign accept    = req_valid && !req_stall;

  // --------------------------------------------------------------------------
  // Outstanding bitmap. It is read with the incoming seq_num at accept, so
  // the bit lines up with the item register. A write from the item ahead in
  // the same cycle is forwarded by the RAM.
  // --------------------------------------------------------------------------
  assign map_ra = MAP_AW'(CMP_W'(req.seq_num));

  nrsq_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (1)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_wa),
    .wdata (map_wd),
    .re    (accept),
    .raddr (map_ra),
    .rdata (map_bit)
  );

  // --------------------------------------------------------------------------
  // Retransmit stack. Its top entry is valid in the cycle after any change.
  // --------------------------------------------------------------------------
  nrsq_stack #(
    .DEPTH (RETX_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (stk_ctl),
    .stat (stk_stat)
  );

  // --------------------------------------------------------------------------
  // Decision for the item in the item register. Bitmap entries at or above
  // next_fresh were never written since reset, so they count as clear.
  // State changes are only committed when the item moves on.
  // --------------------------------------------------------------------------
  always_comb begin
    seq_c       = CMP_W'(item.seq_num);
    limit       = (CMP_W'(num_packets) > SPACE_C) ? SPACE_C : CMP_W'(num_packets);
    outstanding = map_bit[0] && (seq_c != '0) && (seq_c <= SPACE_C) &&
                  (seq_c < next_fresh);

    rsp_next.status  = nrsq_pkg::ST_NONE;
    rsp_next.seq_out = '0;
    map_we           = 1'b0;
    map_wa           = MAP_AW'(seq_c);
    map_wd           = 1'b0;
    fresh_inc        = 1'b0;
    stk_ctl.push     = 1'b0;
    stk_ctl.pop      = 1'b0;
    stk_ctl.data     = item.seq_num;

    case (item.func)
      nrsq_pkg::FUNC_SEND: begin
        if (!stk_stat.empty) begin
          // Retransmissions are served before fresh numbers.
          stk_ctl.pop      = 1'b1;
          map_we           = 1'b1;
          map_wa           = MAP_AW'(CMP_W'(stk_stat.top));
          map_wd           = 1'b1;
          rsp_next.status  = nrsq_pkg::ST_SENT;
          rsp_next.seq_out = stk_stat.top;
        end else if (next_fresh <= limit) begin
          fresh_inc        = 1'b1;
          map_we           = 1'b1;
          map_wa           = MAP_AW'(next_fresh);
          map_wd           = 1'b1;
          rsp_next.status  = nrsq_pkg::ST_SENT;
          rsp_next.seq_out = next_fresh[nrsq_pkg::SEQ_W-1:0];
        end
      end
      nrsq_pkg::FUNC_ACK: begin
        rsp_next.seq_out = item.seq_num;
        if (!outstanding) begin
          rsp_next.status = nrsq_pkg::ST_NOTOUT;
        end else begin
          rsp_next.status = nrsq_pkg::ST_ACKED;
          map_we          = 1'b1;
        end
      end
      nrsq_pkg::FUNC_NACK: begin
        rsp_next.seq_out = item.seq_num;
        if (!outstanding) begin
          rsp_next.status = nrsq_pkg::ST_NOTOUT;
        end else if (stk_stat.full) begin
          // Dropped: the number stays outstanding.
          rsp_next.status = nrsq_pkg::ST_FULL;
        end else begin
          rsp_next.status = nrsq_pkg::ST_NACKQ;
          stk_ctl.push    = 1'b1;
          map_we          = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!adv) begin
      map_we       = 1'b0;
      fresh_inc    = 1'b0;
      stk_ctl.push = 1'b0;
      stk_ctl.pop  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
      next_fresh  <= CMP_W'(1);
      num_packets <= '0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (adv) begin
        item_valid <= 1'b0;
      end
      if (adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (fresh_inc) begin
        next_fresh <= next_fresh + CMP_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        num_packets <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_reset_empties : assert property (@(posedge clk)
    rst |=> (!item_valid && !rsp_valid))
    else $error("pipeline not empty after reset");

  a_fresh_bound : assert property (@(posedge clk) disable iff (rst)
    next_fresh <= (SPACE_C + CMP_W'(1)))
    else $error("fresh counter ran past the sequence space");

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    !(stk_ctl.push && stk_stat.full))
    else $error("push into a full retransmit stack");

  a_sent_nonzero : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == nrsq_pkg::ST_SENT)) |-> (rsp.seq_out != '0))
    else $error("sent beat carries sequence number zero");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    (adv && (rsp_next.status == nrsq_pkg::ST_NONE)) |=>
    (rsp_valid && (rsp.seq_out == '0)))
    else $error("nothing-to-send beat carries a sequence number");

endmodule
